@@ hw/rtl/inverted_repeat_element_finder_macros.svh @@
// Assertion helpers used by the top-level finder RTL file.
`ifndef INVERTED_REPEAT_ELEMENT_FINDER_MACROS_SVH
`define INVERTED_REPEAT_ELEMENT_FINDER_MACROS_SVH

// Same-cycle implication on clk_i, off while rst_ni is low.
`define IREF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication on clk_i, off while rst_ni is low.
`define IREF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/irefind_pkg.sv @@
`timescale 1ns / 1ps

package irefind_pkg;

  // Signed sequence position, wide enough for offsets around a 32-bit index
  typedef logic signed [35:0] pos_t;

  localparam logic [7:0] SymA   = 8'h41;
  localparam logic [7:0] SymT   = 8'h54;
  localparam logic [7:0] SymC   = 8'h43;
  localparam logic [7:0] SymG   = 8'h47;
  localparam logic [7:0] SymN   = 8'h4E;
  localparam logic [7:0] SymPad = 8'h2D;

  localparam int CfgDataW = 10;

  typedef enum logic [2:0] {
    CfgSeedLen,
    CfgInvMax,
    CfgDirMin,
    CfgDirMax,
    CfgSpanMin,
    CfgSpanMax,
    CfgFlank,
    CfgSeedMin
  } cfg_idx_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] symbol;
  } in_t;

  typedef struct packed {
    logic [31:0] start_pos;
    logic [31:0] end_pos;
    logic [5:0]  direct_len;
    logic [5:0]  inverted_len;
    logic [5:0]  seed_matches;
    logic [5:0]  direct_at;
    logic [5:0]  inverted_at;
    logic [9:0]  element_at;
    logic [7:0]  flank_at;
    logic [31:0] hit_index;
    logic        overflow;
    logic        last;
  } out_t;

  // Fill status of the window, used to decide which positions read as pad
  typedef struct packed {
    logic [31:0] bases_seen;
    logic [31:0] pad_ticks;
  } win_stat_t;

  function automatic pos_t to_pos(logic [31:0] x);
    return pos_t'({4'b0000, x});
  endfunction

  function automatic logic pairs(logic [7:0] a, logic [7:0] b);
    return (a == SymA && b == SymT) || (a == SymT && b == SymA) ||
           (a == SymC && b == SymG) || (a == SymG && b == SymC);
  endfunction

  function automatic logic is_base(logic [7:0] a);
    return a == SymA || a == SymT || a == SymC || a == SymG;
  endfunction

  function automatic logic is_at(logic [7:0] a);
    return a == SymA || a == SymT;
  endfunction

endpackage

@@ hw/rtl/inverted_repeat_element_finder.sv @@
`timescale 1ns / 1ps
// A beat is taken only while idle; its hits leave through a one-deep
// hold stage and the output register, the last one as the scan of its start ends.
// Each beat scans at most one start, and no new beat is taken until that scan ends;
// every base compared or counted is one access of the single window read port.
// Reset clears all control state; the window reads as pad up to the fill count.
`include "inverted_repeat_element_finder_macros.svh"

module inverted_repeat_element_finder #(
  parameter int unsigned WindowDepth = 1024,
  parameter int unsigned MaxHits     = 64
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  irefind_pkg::in_t                     in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output irefind_pkg::out_t                    out_data_o,
  input  logic                                 cfg_we_i,
  input  irefind_pkg::cfg_idx_e                cfg_idx_i,
  input  logic [irefind_pkg::CfgDataW-1:0]     cfg_data_i
);

  localparam int unsigned NW = $clog2(MaxHits + 1);

  typedef enum logic [4:0] {
    ST_IDLE, ST_CHECK, ST_VINIT, ST_SA_R, ST_SA_D, ST_SB_R, ST_SB_D, ST_SEVAL,
    ST_DJ, ST_DA_R, ST_DA_D, ST_DB_R, ST_DB_D, ST_HITCHK, ST_IA_R, ST_IA_D,
    ST_IB_R, ST_IB_D, ST_CNT_INIT, ST_CR, ST_CD, ST_EMIT, ST_VNEXT, ST_FIN
  } st_e;

  st_e               state_q;
  logic [5:0]        seed_len_q, inv_max_q, dir_min_q, dir_max_q, seed_min_q;
  logic [9:0]        span_min_q, span_max_q;
  logic [7:0]        flank_q;
  logic [31:0]       bases_seen_q, pad_ticks_q, next_start_q, hit_cnt_q, u_q;
  logic              ended_q, kind_q;
  irefind_pkg::pos_t vend_q, v_q, s_q, cend_q;
  logic [5:0]        m_q, j_q, lpc_q, c1_q, dr_q, tl_q, dat_q, iat_q;
  logic              kill_q, more_q, pend_q;
  logic [7:0]        a_q, fat_q;
  logic [9:0]        eat_q;
  logic [NW-1:0]     n_q;
  irefind_pkg::out_t pend_data_q, out_data_q, hit_w;
  logic              out_valid_q;

  logic              in_acc, wr_en, slot_free, pair_w, base_go, pad_go;
  logic [7:0]        rd_sym;
  logic [5:0]        mlim, dmx, c1e;
  logic [31:0]       u_w;
  irefind_pkg::pos_t rd_pos, u_s, uw_s, seen_s, sl_s, m_s, j_s, dr_s, tl_s;
  irefind_pkg::pos_t vs_s, ut_s, ahead_s, cap_s, vlim_s, udr_s;
  irefind_pkg::win_stat_t stat;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && (state_q == ST_IDLE);
  assign wr_en       = in_acc && !in_data_i.kind && !ended_q && (bases_seen_q != '1);
  assign slot_free   = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign stat        = '{bases_seen: bases_seen_q, pad_ticks: pad_ticks_q};

  irefind_window #(
    .Depth(WindowDepth)
  ) u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_en_i (wr_en),
    .wr_sym_i(in_data_i.symbol),
    .stat_i  (stat),
    .rd_pos_i(rd_pos),
    .rd_sym_o(rd_sym)
  );

  // Position arithmetic
  always_comb begin
    u_w     = (next_start_q < 32'(dir_min_q)) ? 32'(dir_min_q) : next_start_q;
    uw_s    = irefind_pkg::to_pos(u_w);
    u_s     = irefind_pkg::to_pos(u_q);
    seen_s  = irefind_pkg::to_pos(bases_seen_q);
    sl_s    = irefind_pkg::to_pos(32'(seed_len_q));
    m_s     = irefind_pkg::to_pos(32'(m_q));
    j_s     = irefind_pkg::to_pos(32'(j_q));
    dr_s    = irefind_pkg::to_pos(32'(dr_q));
    tl_s    = irefind_pkg::to_pos(32'(tl_q));
    vs_s    = v_q + sl_s;
    ut_s    = u_s + tl_s;
    udr_s   = u_s - dr_s;
    dmx     = (dir_max_q > dir_min_q) ? dir_max_q : dir_min_q;
    ahead_s = irefind_pkg::to_pos(32'(span_max_q)) + sl_s +
              irefind_pkg::to_pos(32'(dmx)) + irefind_pkg::to_pos(32'(inv_max_q));
    base_go = ((seen_s - 1) >= (uw_s + ahead_s)) && (u_w != '1);
    cap_s   = seen_s - irefind_pkg::to_pos(32'(dir_min_q)) - sl_s;
    pad_go  = (uw_s < (cap_s - irefind_pkg::to_pos(32'(span_min_q)))) && (u_w != '1);
    vlim_s  = uw_s + irefind_pkg::to_pos(32'(span_max_q));
    mlim    = (seed_len_q < 6'd2) ? 6'd2 : seed_len_q;
    c1e     = kill_q ? 6'd0 : c1_q;
    pair_w  = irefind_pkg::pairs(a_q, rd_sym);
  end

  // Read address by phase
  always_comb begin
    unique case (state_q)
      ST_SA_R: rd_pos = u_s + m_s;
      ST_SB_R: rd_pos = vs_s - 1 - m_s;
      ST_DA_R: rd_pos = u_s - j_s + m_s;
      ST_DB_R: rd_pos = vs_s + m_s;
      ST_IA_R: rd_pos = u_s + j_s;
      ST_IB_R: rd_pos = vs_s - j_s - 1;
      default: rd_pos = s_q;
    endcase
  end

  // Hit record for the hold stage
  always_comb begin
    hit_w              = '0;
    hit_w.start_pos    = u_q + 32'd1;
    hit_w.end_pos      = vs_s[31:0];
    hit_w.direct_len   = dr_q;
    hit_w.inverted_len = tl_q;
    hit_w.seed_matches = c1_q;
    hit_w.direct_at    = dat_q;
    hit_w.inverted_at  = iat_q;
    hit_w.element_at   = eat_q;
    hit_w.flank_at     = fat_q;
    hit_w.hit_index    = hit_cnt_q;
  end

  // Sequencer, configuration and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      seed_len_q   <= 6'd9;
      inv_max_q    <= 6'd30;
      dir_min_q    <= 6'd2;
      dir_max_q    <= 6'd30;
      span_min_q   <= 10'd51;
      span_max_q   <= 10'd591;
      flank_q      <= 8'd50;
      seed_min_q   <= 6'd9;
      bases_seen_q <= '0;
      pad_ticks_q  <= '0;
      next_start_q <= '0;
      hit_cnt_q    <= '0;
      ended_q      <= 1'b0;
      kind_q       <= 1'b0;
      u_q          <= '0;
      vend_q       <= '0;
      v_q          <= '0;
      s_q          <= '0;
      cend_q       <= '0;
      m_q          <= '0;
      j_q          <= '0;
      lpc_q        <= '0;
      c1_q         <= '0;
      dr_q         <= '0;
      tl_q         <= '0;
      dat_q        <= '0;
      iat_q        <= '0;
      fat_q        <= '0;
      eat_q        <= '0;
      a_q          <= '0;
      kill_q       <= 1'b0;
      more_q       <= 1'b0;
      pend_q       <= 1'b0;
      n_q          <= '0;
      pend_data_q  <= '0;
      out_data_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          irefind_pkg::CfgSeedLen: seed_len_q <= cfg_data_i[5:0];
          irefind_pkg::CfgInvMax:  inv_max_q  <= cfg_data_i[5:0];
          irefind_pkg::CfgDirMin:  dir_min_q  <= cfg_data_i[5:0];
          irefind_pkg::CfgDirMax:  dir_max_q  <= cfg_data_i[5:0];
          irefind_pkg::CfgSpanMin: span_min_q <= cfg_data_i[9:0];
          irefind_pkg::CfgSpanMax: span_max_q <= cfg_data_i[9:0];
          irefind_pkg::CfgFlank:   flank_q    <= cfg_data_i[7:0];
          irefind_pkg::CfgSeedMin: seed_min_q <= cfg_data_i[5:0];
        endcase
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            kind_q <= in_data_i.kind;
            if (in_data_i.kind) begin
              ended_q <= 1'b1;
              if (pad_ticks_q != '1) begin
                pad_ticks_q <= pad_ticks_q + 32'd1;
              end
              state_q <= ST_CHECK;
            end else if (!ended_q && (bases_seen_q != '1)) begin
              bases_seen_q <= bases_seen_q + 32'd1;
              state_q      <= ST_CHECK;
            end
          end
        end
        // Decide whether this beat scans a start, and set its right range
        ST_CHECK: begin
          if (kind_q ? pad_go : base_go) begin
            u_q    <= u_w;
            v_q    <= uw_s + irefind_pkg::to_pos(32'(span_min_q));
            vend_q <= (kind_q && (cap_s < vlim_s)) ? cap_s : vlim_s;
            lpc_q  <= (u_w < 32'(dir_max_q)) ? u_w[5:0] : dir_max_q;
            n_q    <= '0;
            more_q <= 1'b0;
            state_q <= ST_VINIT;
          end else begin
            state_q <= ST_IDLE;
          end
        end
        ST_VINIT: begin
          if (v_q >= vend_q) begin
            state_q <= ST_FIN;
          end else begin
            m_q     <= '0;
            c1_q    <= '0;
            kill_q  <= 1'b0;
            state_q <= ST_SA_R;
          end
        end
        // Seed compare, one base pair per step
        ST_SA_R: state_q <= ST_SA_D;
        ST_SA_D: begin
          a_q     <= rd_sym;
          state_q <= ST_SB_R;
        end
        ST_SB_R: state_q <= ST_SB_D;
        ST_SB_D: begin
          if ((m_q < seed_len_q) && pair_w) begin
            c1_q <= c1_q + 6'd1;
          end
          if ((m_q < 6'd2) && irefind_pkg::is_base(a_q) && !pair_w) begin
            kill_q <= 1'b1;
          end
          if (({1'b0, m_q} + 7'd1) == {1'b0, mlim}) begin
            state_q <= ST_SEVAL;
          end else begin
            m_q     <= m_q + 6'd1;
            state_q <= ST_SA_R;
          end
        end
        ST_SEVAL: begin
          c1_q <= c1e;
          if (c1e < seed_min_q) begin
            state_q <= ST_VNEXT;
          end else begin
            j_q     <= lpc_q;
            state_q <= ST_DJ;
          end
        end
        // Direct repeat, longest length first
        ST_DJ: begin
          if (j_q < dir_min_q) begin
            state_q <= ST_VNEXT;
          end else if (j_q == 6'd0) begin
            dr_q    <= '0;
            state_q <= ST_HITCHK;
          end else begin
            m_q     <= '0;
            state_q <= ST_DA_R;
          end
        end
        ST_DA_R: state_q <= ST_DA_D;
        ST_DA_D: begin
          a_q     <= rd_sym;
          state_q <= ST_DB_R;
        end
        ST_DB_R: state_q <= ST_DB_D;
        ST_DB_D: begin
          if ((a_q != rd_sym) || (a_q == irefind_pkg::SymN)) begin
            if (j_q == dir_min_q) begin
              state_q <= ST_VNEXT;
            end else begin
              j_q     <= j_q - 6'd1;
              state_q <= ST_DJ;
            end
          end else if (({1'b0, m_q} + 7'd1) == {1'b0, j_q}) begin
            dr_q    <= j_q;
            state_q <= ST_HITCHK;
          end else begin
            m_q     <= m_q + 6'd1;
            state_q <= ST_DA_R;
          end
        end
        ST_HITCHK: begin
          if (n_q >= NW'(MaxHits)) begin
            more_q  <= 1'b1;
            state_q <= ST_FIN;
          end else begin
            tl_q    <= (inv_max_q < seed_len_q) ? seed_len_q : inv_max_q;
            j_q     <= seed_len_q;
            state_q <= (seed_len_q < inv_max_q) ? ST_IA_R : ST_CNT_INIT;
          end
        end
        // Inverted repeat extension
        ST_IA_R: state_q <= ST_IA_D;
        ST_IA_D: begin
          a_q     <= rd_sym;
          state_q <= ST_IB_R;
        end
        ST_IB_R: state_q <= ST_IB_D;
        ST_IB_D: begin
          if (!pair_w) begin
            tl_q    <= j_q;
            state_q <= ST_CNT_INIT;
          end else if (({1'b0, j_q} + 7'd1) >= {1'b0, inv_max_q}) begin
            state_q <= ST_CNT_INIT;
          end else begin
            j_q     <= j_q + 6'd1;
            state_q <= ST_IA_R;
          end
        end
        // A/T sweep over flank, direct repeat and element in one pass
        ST_CNT_INIT: begin
          s_q     <= udr_s - irefind_pkg::to_pos(32'(flank_q));
          cend_q  <= (vs_s > ut_s) ? vs_s : ut_s;
          fat_q   <= '0;
          dat_q   <= '0;
          iat_q   <= '0;
          eat_q   <= '0;
          state_q <= ST_CR;
        end
        ST_CR: state_q <= (s_q >= cend_q) ? ST_EMIT : ST_CD;
        ST_CD: begin
          if (irefind_pkg::is_at(rd_sym)) begin
            if (s_q < u_s) begin
              if (fat_q != '1) fat_q <= fat_q + 8'd1;
              if ((s_q >= udr_s) && (dat_q != '1)) dat_q <= dat_q + 6'd1;
            end else begin
              if ((s_q < vs_s) && (eat_q != '1)) eat_q <= eat_q + 10'd1;
              if ((s_q < ut_s) && (iat_q != '1)) iat_q <= iat_q + 6'd1;
            end
          end
          s_q     <= s_q + 1;
          state_q <= ST_CR;
        end
        // Older hit goes out, new one waits to learn if it is the last
        ST_EMIT: begin
          if (!pend_q || slot_free) begin
            if (pend_q) begin
              out_data_q  <= pend_data_q;
              out_valid_q <= 1'b1;
            end
            pend_data_q <= hit_w;
            pend_q      <= 1'b1;
            hit_cnt_q   <= hit_cnt_q + 32'd1;
            n_q         <= n_q + 1'b1;
            state_q     <= ST_VNEXT;
          end
        end
        ST_VNEXT: begin
          v_q     <= v_q + 1;
          state_q <= ST_VINIT;
        end
        ST_FIN: begin
          if (!pend_q || slot_free) begin
            if (pend_q) begin
              out_data_q          <= pend_data_q;
              out_data_q.last     <= 1'b1;
              out_data_q.overflow <= more_q;
              out_valid_q         <= 1'b1;
              pend_q              <= 1'b0;
            end
            next_start_q <= u_q + 32'd1;
            state_q      <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  `IREF_ASSERT_IMP(a_idle_no_pend, (state_q == ST_IDLE), !pend_q, "hit held at idle")
  `IREF_ASSERT_IMP(a_pend_counted, pend_q, (n_q != '0), "held hit not counted")
  `IREF_ASSERT_IMP(a_sweep_bound, (state_q == ST_CD), (s_q < cend_q), "sweep past end")
  `IREF_ASSERT_IMP(a_direct_idx, (state_q == ST_DA_R), ((m_q < j_q) && (j_q >= dir_min_q)), "direct index out of range")
  `IREF_ASSERT_NEXT(a_fin_done, ((state_q == ST_FIN) && (!pend_q || slot_free)), (state_q == ST_IDLE), "scan end stuck")

endmodule

@@ hw/rtl/irefind_window.sv @@
`timescale 1ns / 1ps

// Sliding sequence window: one write port, one registered read port.
// Positions outside the written, still-held range read as the pad symbol.
module irefind_window #(
  parameter int unsigned Depth = 1024
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    wr_en_i,
  input  logic [7:0]              wr_sym_i,
  input  irefind_pkg::win_stat_t  stat_i,
  input  irefind_pkg::pos_t       rd_pos_i,
  output logic [7:0]              rd_sym_o
);

  localparam int unsigned AW = $clog2(Depth);

  logic [7:0]        mem [Depth];
  logic [AW-1:0]     wptr_q, wptr_d;
  logic [AW-1:0]     ridx;
  logic [AW:0]       diff_w, wptr_w;
  logic [7:0]        rdata_q;
  logic              pad_q, pad_d;
  irefind_pkg::pos_t seen_s, fill_s, diff_s;

  // Range check and translation of a position to its slot
  always_comb begin
    seen_s = irefind_pkg::to_pos(stat_i.bases_seen);
    fill_s = seen_s + irefind_pkg::to_pos(stat_i.pad_ticks);
    pad_d  = (rd_pos_i < 0) || (rd_pos_i >= seen_s) ||
             ((rd_pos_i + irefind_pkg::pos_t'(Depth)) < fill_s);
    diff_s = seen_s - rd_pos_i;
    diff_w = diff_s[AW:0];
    wptr_w = {1'b0, wptr_q};
    if (wptr_w >= diff_w) begin
      ridx = AW'(wptr_w - diff_w);
    end else begin
      ridx = AW'(wptr_w + (AW+1)'(Depth) - diff_w);
    end
  end

  // Write pointer wraps at the depth
  always_comb begin
    wptr_d = wptr_q;
    if (wr_en_i) begin
      wptr_d = (wptr_q == AW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
    end else begin
      wptr_q <= wptr_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wptr_q] <= wr_sym_i;
    end
    rdata_q <= mem[ridx];
    pad_q   <= pad_d;
  end

  assign rd_sym_o = pad_q ? irefind_pkg::SymPad : rdata_q;

endmodule
